/* hw/rtl/linear_probe_hash_map_core_defines.svh */
// assertion macros for the hash map core
`ifndef LINEAR_PROBE_HASH_MAP_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_CORE_DEFINES_SVH

// same-cycle implication
`define LPHM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lphm_pkg.sv */
`default_nettype none
package lphm_pkg;

  localparam int unsigned SLOTS_DEF      = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned KEY_W          = 31;
  localparam int unsigned PORT_VAL_W     = 32;
  localparam logic [31:0] HASH_MULT      = 32'd2654435761;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_LOAD,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_RM_RD,
    S_RM_CHK,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/lphm_mem.sv */
`default_nettype none
module lphm_mem import lphm_pkg::*; #(
  parameter int unsigned DEPTH  = SLOTS_DEF,
  parameter int unsigned DATA_W = 1 + KEY_W + VALUE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/lphm_hash.sv */
`default_nettype none
module lphm_hash import lphm_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic [KEY_W-1:0]         key,
  output logic      [$clog2(SLOTS)-1:0] home
);

  logic [31:0] prod;

  // low 32 bits of the product, slot count is a power of two
  assign prod = {1'b0, key} * HASH_MULT;

  always_ff @(posedge clk) begin
    home <= prod[$clog2(SLOTS)-1:0];
  end

endmodule
`default_nettype wire

/* hw/rtl/linear_probe_hash_map_core.sv */
// lookup/insert: S_HASH and S_LOAD, then a read and a check per probed slot, then the output register
// remove also walks the cluster (S_RM_RD, S_RM_CHK) and re-places each entry in it via hash and probe
// one transaction at a time, set by the sequential probe loop
// reset: clearing pass over every slot of the slot memory before the first transaction
// entry count cleared by reset, slot count must be a power of two
`default_nettype none
module linear_probe_hash_map_core import lphm_pkg::*; #(
  parameter int unsigned SLOTS      = SLOTS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_cmd,
  input  wire logic [KEY_W-1:0]      in_key,
  input  wire logic [PORT_VAL_W-1:0] in_value_in,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [1:0]            out_status,
  output logic      [PORT_VAL_W-1:0] out_value_out
);

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned DATA_W = 1 + KEY_W + VALUE_BITS;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      n_r, n_nxt;
  logic [IDX_W-1:0]      nxt_r, nxt_nxt;
  logic [CNT_W-1:0]      m_r, m_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      clr_r, clr_nxt;
  logic                  mv_r, mv_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [VALUE_BITS-1:0] res_val_r, res_val_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [VALUE_BITS-1:0] out_val_r, out_val_nxt;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [DATA_W-1:0]     mem_wdata, mem_rdata;
  logic [IDX_W-1:0]      home;

  logic                  rd_used, rd_match, exhaust, full;
  logic [KEY_W-1:0]      rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic [63:0]           in_val64, out_val64;
  logic [VALUE_BITS-1:0] in_val_cut;

  assign in_val64   = {32'd0, in_value_in};
  assign in_val_cut = in_val64[VALUE_BITS-1:0];
  assign out_val64  = 64'(out_val_r);

  assign rd_used  = mem_rdata[DATA_W-1];
  assign rd_key   = mem_rdata[DATA_W-2 -: KEY_W];
  assign rd_val   = mem_rdata[VALUE_BITS-1:0];
  assign rd_match = rd_key == key_r;
  assign exhaust  = n_r == IDX_W'(SLOTS - 1);
  assign full     = cnt_r >= CNT_W'(SLOTS / 2);

  lphm_mem #(.DEPTH(SLOTS), .DATA_W(DATA_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lphm_hash #(.SLOTS(SLOTS)) u_hash (
    .clk  (clk),
    .key  (key_r),
    .home (home)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      mv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      mv_r        <= mv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    nxt_r        <= nxt_nxt;
    m_r          <= m_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    nxt_nxt        = nxt_r;
    m_nxt          = m_r;
    cnt_nxt        = cnt_r;
    clr_nxt        = clr_r;
    mv_nxt         = mv_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    out_status_nxt = out_status_r;
    out_val_nxt    = out_val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    in_ready       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = {1'b1, key_r, val_r};
    mem_raddr      = (state_r == S_RM_RD) ? nxt_r : idx_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt     = cmd_t'(in_cmd);
          key_nxt     = in_key;
          val_nxt     = in_val_cut;
          mv_nxt      = 1'b0;
          res_val_nxt = '0;
          if (cmd_t'(in_cmd) == CMD_NONE) begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        idx_nxt   = home;
        n_nxt     = '0;
        state_nxt = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        state_nxt = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        priority if (mv_r) begin
          // re-placing a cluster entry
          if (!rd_used) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          if (!rd_used || exhaust) begin
            nxt_nxt   = nxt_r + 1'b1;
            m_nxt     = m_r + 1'b1;
            state_nxt = S_RM_RD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            n_nxt     = n_r + 1'b1;
            state_nxt = S_PROBE_RD;
          end
        end else if (!rd_used) begin
          state_nxt = S_DONE;
          unique case (cmd_r)
            CMD_INSERT: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we         = 1'b1;
                cnt_nxt        = cnt_r + 1'b1;
                res_status_nxt = ST_OK;
              end
            end
            default: res_status_nxt = ST_NOT_FOUND;
          endcase
        end else if (rd_match) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
          unique case (cmd_r)
            CMD_INSERT: mem_we = 1'b1;
            CMD_LOOKUP: res_val_nxt = rd_val;
            CMD_REMOVE: begin
              mem_we    = 1'b1;
              mem_wdata = '0;
              cnt_nxt   = cnt_r - 1'b1;
              nxt_nxt   = idx_r + 1'b1;
              m_nxt     = '0;
              state_nxt = S_RM_RD;
            end
            default: res_status_nxt = ST_NOT_FOUND;
          endcase
        end else if (exhaust) begin
          res_status_nxt = (cmd_r == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          n_nxt     = n_r + 1'b1;
          state_nxt = S_PROBE_RD;
        end
      end
      S_RM_RD: begin
        if (m_r == CNT_W'(SLOTS)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RM_CHK;
        end
      end
      S_RM_CHK: begin
        if (!rd_used) begin
          state_nxt = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = nxt_r;
          mem_wdata = '0;
          cnt_nxt   = cnt_r - 1'b1;
          key_nxt   = rd_key;
          val_nxt   = rd_val;
          mv_nxt    = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_val_nxt    = res_val_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_val64[PORT_VAL_W-1:0];

endmodule
`default_nettype wire

/* hw/rtl/lphm_checker.sv */
`default_nettype none
`include "linear_probe_hash_map_core_defines.svh"
module lphm_checker import lphm_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [1:0]            out_status,
  input wire logic [PORT_VAL_W-1:0] out_value_out
);

  `LPHM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_value_out), "result dropped while stalled")
  `LPHM_ASSERT_NOW(a_status_code, out_valid, out_status <= ST_FULL, "bad status code")
  `LPHM_ASSERT_NOW(a_value_zero, out_valid && out_status != ST_OK,
    out_value_out == '0, "value on failed transaction")
  `LPHM_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
    "second transaction taken while busy")

endmodule

bind linear_probe_hash_map_core lphm_checker u_lphm_checker (.*);
`default_nettype wire
